FILE: rtl/core/lps_pkg.sv
package lps_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned ERR_BITS   = COORD_BITS + 2;
  localparam int unsigned COLOR_BITS = 16;
  localparam int unsigned CFG_BITS   = 10;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic [CFG_BITS-1:0]        cfg_data_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } op_e;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    op_e    op;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t pixel_color;
  } in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t out_color;
    logic   inside_res;
    logic   last;
  } out_t;

  // running line state, shared by setup, step and the top level registers
  typedef struct packed {
    logic   steep;
    coord_t major_pos;
    coord_t minor_pos;
    coord_t major_end;
    coord_t major_span;
    coord_t minor_span;
    err_t   error;
    logic   minor_down;
    color_t color;
  } line_t;

endpackage

FILE: rtl/core/lps_setup.sv
module lps_setup
  import lps_pkg::*;
(
  input  in_t   load_i,
  output line_t line_o
);

  coord_t dx, dy;
  logic   steep;
  coord_t a_maj, a_min, b_maj, b_min;
  coord_t lo_maj, lo_min, hi_maj, hi_min;
  coord_t maj_span;

  always_comb begin
    dx = (load_i.start_x > load_i.end_x) ? load_i.start_x - load_i.end_x
                                         : load_i.end_x - load_i.start_x;
    dy = (load_i.start_y > load_i.end_y) ? load_i.start_y - load_i.end_y
                                         : load_i.end_y - load_i.start_y;
    steep = dy > dx;

    a_maj = steep ? load_i.start_y : load_i.start_x;
    a_min = steep ? load_i.start_x : load_i.start_y;
    b_maj = steep ? load_i.end_y   : load_i.end_x;
    b_min = steep ? load_i.end_x   : load_i.end_y;

    // order the ends so the major coordinate rises
    if (a_maj > b_maj) begin
      lo_maj = b_maj;
      lo_min = b_min;
      hi_maj = a_maj;
      hi_min = a_min;
    end else begin
      lo_maj = a_maj;
      lo_min = a_min;
      hi_maj = b_maj;
      hi_min = b_min;
    end

    maj_span = hi_maj - lo_maj;

    line_o.steep      = steep;
    line_o.major_pos  = lo_maj;
    line_o.minor_pos  = lo_min;
    line_o.major_end  = hi_maj;
    line_o.major_span = maj_span;
    line_o.minor_span = (lo_min > hi_min) ? lo_min - hi_min : hi_min - lo_min;
    line_o.minor_down = !(lo_min < hi_min);
    line_o.error      = err_t'({3'b000, maj_span[COORD_BITS-1:1]});
    line_o.color      = load_i.pixel_color;
  end

endmodule

FILE: rtl/core/lps_step.sv
module lps_step
  import lps_pkg::*;
(
  input  line_t     line_i,
  input  cfg_data_t width_i,
  input  cfg_data_t height_i,
  output out_t      pixel_o,
  output line_t     line_o
);

  coord_t px, py;
  err_t   err_sub;

  always_comb begin
    px = line_i.steep ? line_i.minor_pos : line_i.major_pos;
    py = line_i.steep ? line_i.major_pos : line_i.minor_pos;

    pixel_o.pixel_x    = px;
    pixel_o.pixel_y    = py;
    pixel_o.out_color  = line_i.color;
    pixel_o.inside_res = (px < width_i) && (py < height_i);
    pixel_o.last       = line_i.major_pos >= line_i.major_end;

    err_sub = line_i.error - $signed({2'b00, line_i.minor_span});

    line_o           = line_i;
    line_o.major_pos = line_i.major_pos + coord_t'(1);
    if (err_sub[ERR_BITS-1]) begin
      // error went negative: move the minor coordinate and add the span back
      line_o.minor_pos = line_i.minor_down ? line_i.minor_pos - coord_t'(1)
                                           : line_i.minor_pos + coord_t'(1);
      line_o.error     = err_sub + $signed({2'b00, line_i.major_span});
    end else begin
      line_o.error = err_sub;
    end
  end

endmodule

FILE: rtl/core/line_pixel_stepper.sv
// channel  | direction | signals                               | payload
// ---------+-----------+---------------------------------------+-------------------
// in       | input     | in_valid_i / in_ready_o / in_data_i   | op, endpoints, color
// out      | output    | out_valid_o / out_ready_i / out_data_o| pixel, color, flags
// cfg      | input     | cfg_we_i / cfg_idx_i / cfg_data_i     | screen width/height
//
// an accepted transfer is resolved in the cycle it arrives,
// the pixel lands in the output register on the same edge as the state update
// a new item is taken every cycle while the output register is empty or drained
// reset (async, active low) clears line state, busy and output valid; the screen
// registers come up at 240 x 320
// a stalled output holds in_ready_o low; no other source of stall
module line_pixel_stepper
  import lps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,

  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_t       in_data_i,

  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_t      out_data_o,

  input  logic      cfg_we_i,
  input  reg_idx_e  cfg_idx_i,
  input  cfg_data_t cfg_data_i
);

  localparam cfg_data_t WidthReset  = cfg_data_t'(240);
  localparam cfg_data_t HeightReset = cfg_data_t'(320);

  // screen size registers
  cfg_data_t width_q, height_q;

  // line state
  logic  busy_q, busy_d;
  line_t line_q, line_d;

  // output register
  logic  out_valid_q, out_valid_d;
  out_t  out_q;

  // per-transfer decode
  logic  in_xfer;
  logic  do_load;
  logic  do_step;
  line_t load_line;
  line_t step_line;
  out_t  step_pixel;

  // the output stage can take a new pixel when empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign do_load    = in_xfer && (in_data_i.op == OP_LOAD);
  // next while idle is swallowed with no result
  assign do_step    = in_xfer && (in_data_i.op == OP_NEXT) && busy_q;

  lps_setup u_setup (
    .load_i (in_data_i),
    .line_o (load_line)
  );

  lps_step u_step (
    .line_i   (line_q),
    .width_i  (width_q),
    .height_i (height_q),
    .pixel_o  (step_pixel),
    .line_o   (step_line)
  );

  always_comb begin
    busy_d      = busy_q;
    line_d      = line_q;
    out_valid_d = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (do_load) begin
      // a load always restarts, dropping any running line
      line_d = load_line;
      busy_d = 1'b1;
    end else if (do_step) begin
      line_d      = step_line;
      out_valid_d = 1'b1;
      if (step_pixel.last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidthReset;
      height_q    <= HeightReset;
      busy_q      <= 1'b0;
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
          REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      busy_q      <= busy_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pixel payload, loaded only on a step
  always_ff @(posedge clk_i) begin
    if (do_step) begin
      out_q <= step_pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // a step never leaves the error term negative
  a_error_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !line_q.error[ERR_BITS-1])
    else $error("error term negative");

  // the major coordinate never passes the line end while a line runs
  a_major_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (line_q.major_pos <= line_q.major_end))
    else $error("major position beyond line end");

  // a step that emits the last pixel ends the line
  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && step_pixel.last) |=> !busy_q)
    else $error("busy after last pixel");

  // a load always leaves a line running
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |=> busy_q)
    else $error("load did not start a line");
`endif

endmodule
